@@ rtl/core/sat_pkg.sv @@
`default_nettype none

package sat_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;
  localparam int unsigned DEF_PIXEL_BITS = 16;

  // Fixed widths of the payload and configuration fields.
  localparam int unsigned PIXEL_IN_BITS  = 16;
  localparam int unsigned COORD_BITS     = 8;
  localparam int unsigned SUM_BITS       = 32;
  localparam int unsigned MEAN_BITS      = 16;
  localparam int unsigned STATUS_BITS    = 2;
  localparam int unsigned CFG_DATA_BITS  = 9;
  localparam int unsigned CFG_INDEX_BITS = 2;

  // Width used for frame size compares; holds sizes up to 4096.
  localparam int unsigned SIZE_BITS = 13;

  // Width of the shared add/subtract unit, one sign bit above the widest compare.
  localparam int unsigned AU_BITS = 34;

  // Width of the division remainder and the rectangle area.
  localparam int unsigned AREA_BITS = 17;

  // Function codes of an input item.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_BAD_RECT   = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_INCOMPLETE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Reset value of both frame size registers.
  localparam logic [CFG_DATA_BITS-1:0] FRAME_SIZE_RESET = 9'd256;

endpackage

`default_nettype wire

@@ rtl/core/summed_area_table_query.sv @@
`default_nettype none

// Summed-area table with rectangle queries.
// An item is transferred at a rising edge where start is high and busy is low. A load item
// (func_i low) stores the next pixel of the frame in raster order; it gives no result. A query
// item (func_i high) gives one result: rect_sum_o, rect_mean_o and status_o, shown for exactly
// one cycle with result_valid_o high. The receiver cannot hold a result off.
// A load keeps busy high through a read state and a write state, and the next item waits for
// both; the table RAM is read for the entry above and then written, one access per cycle.
// A query whose table is incomplete or whose rectangle is bad gives its result straight from
// the check state. A valid query reads four corners from the single-port table RAM, one per
// cycle, through one shared add/subtract unit, and then divides by the area one quotient bit
// per cycle; a saturating mean is given from the saturation check without division. The next
// item can be transferred in the cycle the result is shown.
// The configuration port writes frame_width (index 0) or frame_height (index 1) at any edge
// where cfg_we_i is high; either write restarts loading at the first pixel of a new frame.
// Reset sets both sizes to 256 and marks the table incomplete. The table RAM is not cleared;
// it needs no clearing pass, since queries are answered only once a whole frame is loaded.
module summed_area_table_query
  import sat_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire logic                      func_i,
  input  wire logic [PIXEL_IN_BITS-1:0]  pixel_value_i,
  input  wire logic [COORD_BITS-1:0]     left_col_i,
  input  wire logic [COORD_BITS-1:0]     top_row_i,
  input  wire logic [COORD_BITS-1:0]     right_col_i,
  input  wire logic [COORD_BITS-1:0]     bottom_row_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  output      logic                      result_valid_o,
  output      logic [SUM_BITS-1:0]       rect_sum_o,
  output      logic [MEAN_BITS-1:0]      rect_mean_o,
  output      logic [STATUS_BITS-1:0]    status_o
);

  localparam int unsigned CW          = $clog2(MAX_WIDTH);
  localparam int unsigned RW          = $clog2(MAX_HEIGHT);
  localparam int unsigned AW          = RW + CW;
  localparam int unsigned TABLE_DEPTH = MAX_HEIGHT * (2 ** CW);
  localparam logic [SIZE_BITS-1:0] MAX_W_S = SIZE_BITS'(MAX_WIDTH);
  localparam logic [SIZE_BITS-1:0] MAX_H_S = SIZE_BITS'(MAX_HEIGHT);
  localparam logic [SUM_BITS-1:0]  PIX_MASK =
    SUM_BITS'((64'd1 << PIXEL_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_RD,
    S_LOAD_WR,
    S_Q_CHECK,
    S_Q_ACC,
    S_Q_SAT,
    S_Q_DIV
  } state_e;

  state_e                   state_q;
  logic [CFG_DATA_BITS-1:0] frame_width_q;
  logic [CFG_DATA_BITS-1:0] frame_height_q;
  logic [CW-1:0]            load_col_q;
  logic [RW-1:0]            load_row_q;
  logic [SUM_BITS-1:0]      row_sum_q;
  logic                     complete_q;
  logic [SUM_BITS-1:0]      pix_q;
  logic [COORD_BITS-1:0]    x0_q, y0_q, x1_q, y1_q;
  logic [1:0]               corner_q;
  logic [SUM_BITS-1:0]      acc_q;
  logic [AREA_BITS-1:0]     area_q;
  logic [AREA_BITS-1:0]     rem_q;
  logic [MEAN_BITS-1:0]     low_q;
  logic [3:0]               div_cnt_q;

  logic [SIZE_BITS-1:0]     frame_w, frame_h;
  logic                     load_wrap_col, load_wrap_row, load_stale;
  logic                     rect_bad;
  logic [15:0]              x0_ext, x1_ext, y0_ext, y1_ext;
  logic [CW-1:0]            col_x1, col_x0m;
  logic [RW-1:0]            row_y1, row_y0m;
  logic [1:0]               corner_next;
  logic [AW-1:0]            corner_addr;
  logic                     corner_used;
  logic [AREA_BITS:0]       trial;
  logic [17:0]              area_prod;
  logic [AU_BITS-1:0]       au_a, au_b, au_y;
  logic                     au_sub;
  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic [SUM_BITS-1:0]      ram_rdata;

  // Frame sizes in use: zero acts as one, and sizes are capped at the table limits.
  always_comb begin
    if (frame_width_q == '0) begin
      frame_w = SIZE_BITS'(1);
    end else if (SIZE_BITS'(frame_width_q) > MAX_W_S) begin
      frame_w = MAX_W_S;
    end else begin
      frame_w = SIZE_BITS'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      frame_h = SIZE_BITS'(1);
    end else if (SIZE_BITS'(frame_height_q) > MAX_H_S) begin
      frame_h = MAX_H_S;
    end else begin
      frame_h = SIZE_BITS'(frame_height_q);
    end
  end

  // Load position tests.
  assign load_wrap_col = (SIZE_BITS'(load_col_q) + SIZE_BITS'(1)) >= frame_w;
  assign load_wrap_row = (SIZE_BITS'(load_row_q) + SIZE_BITS'(1)) >= frame_h;
  assign load_stale    = (SIZE_BITS'(load_col_q) >= frame_w) ||
                         (SIZE_BITS'(load_row_q) >= frame_h);

  // Rectangle check against the frame in use.
  assign rect_bad = (x0_q > x1_q) || (y0_q > y1_q) ||
                    (SIZE_BITS'(x1_q) >= frame_w) || (SIZE_BITS'(y1_q) >= frame_h);

  // Corner coordinates as table columns and rows; a minus-one corner wraps but is then unused.
  assign x0_ext  = 16'(x0_q);
  assign x1_ext  = 16'(x1_q);
  assign y0_ext  = 16'(y0_q);
  assign y1_ext  = 16'(y1_q);
  assign col_x1  = x1_ext[CW-1:0];
  assign col_x0m = x0_ext[CW-1:0] - CW'(1);
  assign row_y1  = y1_ext[RW-1:0];
  assign row_y0m = y0_ext[RW-1:0] - RW'(1);

  // Corner order: bottom right, bottom left, top right, top left.
  assign corner_next = (state_q == S_Q_ACC) ? corner_q + 2'd1 : 2'd0;

  always_comb begin
    case (corner_next)
      2'd0:    corner_addr = {row_y1, col_x1};
      2'd1:    corner_addr = {row_y1, col_x0m};
      2'd2:    corner_addr = {row_y0m, col_x1};
      default: corner_addr = {row_y0m, col_x0m};
    endcase
  end

  // Whether the corner whose data arrives this cycle takes part in the sum.
  always_comb begin
    case (corner_q)
      2'd0:    corner_used = 1'b1;
      2'd1:    corner_used = (x0_q != '0);
      2'd2:    corner_used = (y0_q != '0);
      default: corner_used = (x0_q != '0) && (y0_q != '0);
    endcase
  end

  // Rectangle area: one multiplier, registered before use.
  assign area_prod = (18'(x1_q) - 18'(x0_q) + 18'd1) * (18'(y1_q) - 18'(y0_q) + 18'd1);

  // Next division step: the remainder with the next dividend bit brought in.
  assign trial = {rem_q, low_q[MEAN_BITS-1]};

  // Operand selection for the shared add/subtract unit.
  always_comb begin
    au_a   = '0;
    au_b   = '0;
    au_sub = 1'b0;
    case (state_q)
      S_LOAD_RD: begin
        au_a = AU_BITS'(row_sum_q);
        au_b = AU_BITS'(pix_q);
      end
      S_LOAD_WR: begin
        au_a = AU_BITS'(row_sum_q);
        au_b = (load_row_q != '0) ? AU_BITS'(ram_rdata) : '0;
      end
      S_Q_ACC: begin
        au_a   = (corner_q == 2'd0) ? '0 : AU_BITS'(acc_q);
        au_b   = corner_used ? AU_BITS'(ram_rdata) : '0;
        au_sub = (corner_q == 2'd1) || (corner_q == 2'd2);
      end
      S_Q_SAT: begin
        au_a   = AU_BITS'(acc_q);
        au_b   = AU_BITS'({area_q, 16'd0});
        au_sub = 1'b1;
      end
      S_Q_DIV: begin
        au_a   = AU_BITS'(trial);
        au_b   = AU_BITS'(area_q);
        au_sub = 1'b1;
      end
      default: begin
        au_a = '0;
      end
    endcase
  end

  assign au_y = au_sub ? au_a - au_b : au_a + au_b;

  // Table RAM address: entry above on a load read, the loaded entry on a write, corners in a query.
  always_comb begin
    ram_we = 1'b0;
    case (state_q)
      S_LOAD_RD: ram_addr = {load_row_q - RW'(1), load_col_q};
      S_LOAD_WR: begin
        ram_addr = {load_row_q, load_col_q};
        ram_we   = 1'b1;
      end
      S_Q_CHECK,
      S_Q_ACC:   ram_addr = corner_addr;
      default:   ram_addr = '0;
    endcase
  end

  sat_ram #(
    .DATA_W (SUM_BITS),
    .DEPTH  (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (au_y[SUM_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  assign busy = (state_q != S_IDLE);

  // Sequencer with its datapath registers, the result registers and the frame size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      frame_width_q  <= FRAME_SIZE_RESET;
      frame_height_q <= FRAME_SIZE_RESET;
      load_col_q     <= '0;
      load_row_q     <= '0;
      row_sum_q      <= '0;
      complete_q     <= 1'b0;
      result_valid_o <= 1'b0;
      corner_q       <= '0;
      div_cnt_q      <= '0;
    end else begin
      result_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            pix_q <= SUM_BITS'(pixel_value_i) & PIX_MASK;
            x0_q  <= left_col_i;
            y0_q  <= top_row_i;
            x1_q  <= right_col_i;
            y1_q  <= bottom_row_i;
            if (func_i == FUNC_LOAD) begin
              // A load after a complete frame, or at a position outside the frame, starts a new one.
              if (complete_q || load_stale) begin
                load_col_q <= '0;
                load_row_q <= '0;
                row_sum_q  <= '0;
                complete_q <= 1'b0;
              end
              state_q <= S_LOAD_RD;
            end else begin
              state_q <= S_Q_CHECK;
            end
          end
        end
        S_LOAD_RD: begin
          row_sum_q <= au_y[SUM_BITS-1:0];
          state_q   <= S_LOAD_WR;
        end
        S_LOAD_WR: begin
          if (load_wrap_col) begin
            load_col_q <= '0;
            row_sum_q  <= '0;
            if (load_wrap_row) begin
              load_row_q <= '0;
              complete_q <= 1'b1;
            end else begin
              load_row_q <= load_row_q + RW'(1);
            end
          end else begin
            load_col_q <= load_col_q + CW'(1);
          end
          state_q <= S_IDLE;
        end
        S_Q_CHECK: begin
          if (!complete_q || rect_bad) begin
            rect_sum_o     <= '0;
            rect_mean_o    <= '0;
            status_o       <= !complete_q ? STATUS_INCOMPLETE : STATUS_BAD_RECT;
            result_valid_o <= 1'b1;
            state_q        <= S_IDLE;
          end else begin
            area_q   <= area_prod[AREA_BITS-1:0];
            corner_q <= 2'd0;
            state_q  <= S_Q_ACC;
          end
        end
        S_Q_ACC: begin
          acc_q    <= au_y[SUM_BITS-1:0];
          corner_q <= corner_q + 2'd1;
          if (corner_q == 2'd3) begin
            state_q <= S_Q_SAT;
          end
        end
        S_Q_SAT: begin
          // A sum of at least the area times 2^16 gives a saturated mean.
          if (!au_y[AU_BITS-1]) begin
            rect_sum_o     <= acc_q;
            rect_mean_o    <= '1;
            status_o       <= STATUS_OK;
            result_valid_o <= 1'b1;
            state_q        <= S_IDLE;
          end else begin
            rem_q     <= AREA_BITS'(acc_q[SUM_BITS-1:MEAN_BITS]);
            low_q     <= acc_q[MEAN_BITS-1:0];
            div_cnt_q <= 4'd15;
            state_q   <= S_Q_DIV;
          end
        end
        S_Q_DIV: begin
          // Restoring division, one quotient bit per cycle shifted into the low word.
          if (!au_y[AU_BITS-1]) begin
            rem_q <= au_y[AREA_BITS-1:0];
          end else begin
            rem_q <= trial[AREA_BITS-1:0];
          end
          low_q     <= {low_q[MEAN_BITS-2:0], ~au_y[AU_BITS-1]};
          div_cnt_q <= div_cnt_q - 4'd1;
          if (div_cnt_q == 4'd0) begin
            rect_sum_o     <= acc_q;
            rect_mean_o    <= {low_q[MEAN_BITS-2:0], ~au_y[AU_BITS-1]};
            status_o       <= STATUS_OK;
            result_valid_o <= 1'b1;
            state_q        <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // A size write restarts loading of the frame.
      if (cfg_we_i && (cfg_index_i == REG_FRAME_WIDTH || cfg_index_i == REG_FRAME_HEIGHT)) begin
        if (cfg_index_i == REG_FRAME_WIDTH) begin
          frame_width_q <= cfg_data_i;
        end else begin
          frame_height_q <= cfg_data_i;
        end
        load_col_q <= '0;
        load_row_q <= '0;
        row_sum_q  <= '0;
        complete_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sat_ram.sv @@
`default_nettype none

// Single-port RAM with a registered read. A write cycle does not update the read data.
module sat_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 65536,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     addr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write or read one entry per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire
